FILE: design/cmo_pkg.sv
// Shared types, constants and the default arrow shape for the cursor overlay.
package cmo_pkg;

    localparam int MASK_SIZE  = 32;
    localparam int COORD_BITS = 12;

    // Each mask row is 32 bits, bit 31 is column 0.
    localparam int ROW_W      = 32;
    localparam int COL_BITS   = $clog2(ROW_W);
    localparam int ROW_AW     = $clog2(MASK_SIZE);
    localparam int SIZE_BITS  = 6;
    localparam int SIZE_CAP   = (MASK_SIZE < ROW_W) ? MASK_SIZE : ROW_W;
    localparam int ARROW_ROWS = 16;

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_MOVE  = 2'd2;

    localparam int          REG_IDX_BITS      = 3;
    localparam int          PADDR_BITS        = REG_IDX_BITS + 2;
    localparam logic [2:0]  REG_HOT_X         = 3'd0;
    localparam logic [2:0]  REG_HOT_Y         = 3'd1;
    localparam logic [2:0]  REG_CURSOR_WIDTH  = 3'd2;
    localparam logic [2:0]  REG_CURSOR_HEIGHT = 3'd3;
    localparam logic [2:0]  REG_CURSOR_ENABLE = 3'd4;

    localparam logic [ROW_W-1:0] PIX_BLACK = 32'h0000_0000;
    localparam logic [ROW_W-1:0] PIX_WHITE = 32'h00FF_FFFF;

    typedef struct packed {
        logic [1:0]            mode;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [31:0]           pixel_value;
        logic [4:0]            row_index;
        logic [31:0]           clear_bits;
        logic [31:0]           set_bits;
        logic [COORD_BITS-1:0] new_pointer_x;
        logic [COORD_BITS-1:0] new_pointer_y;
    } item_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        cursor_hit;
    } result_t;

    typedef struct packed {
        logic signed [5:0]     hot_x;
        logic signed [5:0]     hot_y;
        logic [SIZE_BITS-1:0]  cursor_width;
        logic [SIZE_BITS-1:0]  cursor_height;
        logic                  cursor_enable;
    } cfg_t;

    localparam logic [15:0] ARROW_CLR [ARROW_ROWS] = '{
        16'hFFFF, 16'h8001, 16'h8002, 16'h800C, 16'h8010, 16'h8010, 16'h8008, 16'h8004,
        16'h8002, 16'h8001, 16'h8002, 16'h8C04, 16'h9208, 16'h9110, 16'hA0A0, 16'hC040
    };
    localparam logic [15:0] ARROW_SET [ARROW_ROWS] = '{
        16'h0000, 16'h7FFE, 16'h7FFC, 16'h7FF0, 16'h7FE0, 16'h7FE0, 16'h7FF0, 16'h7FF8,
        16'h7FFC, 16'h7FFE, 16'h7FFC, 16'h73F8, 16'h61F0, 16'h60E0, 16'h4040, 16'h0000
    };

    // Reset content of one store row as {clear, set}.
    function automatic logic [2*ROW_W-1:0] arrow_row(input logic [ROW_AW-1:0] row);
        logic [2*ROW_W-1:0] val;
        val = '0;
        if (int'(row) < ARROW_ROWS)
        begin
            val = {ARROW_CLR[row[3:0]], 16'h0000, ARROW_SET[row[3:0]], 16'h0000};
        end
        return val;
    endfunction

endpackage

FILE: design/cursor_mask_overlay_core.sv
// Cursor overlay top level: item pipeline, pointer registers and result register.
//
// The block takes one item per clock while it is not stalled and returns a result for each
// pixel item after the mask store's registered read and then the result register. Load and
// move items take effect at the clock that accepts them, so a pixel that follows in the very
// next cycle already sees the new mask row or pointer. The mask store is a 32-row RAM holding
// both masks side by side; rows not yet loaded read back as the default arrow from the moment
// reset is released, so there is no clearing pass. The block stalls only when the result side
// holds back its ready.
module cursor_mask_overlay_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  cmo_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output cmo_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cmo_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int CW = cmo_pkg::COORD_BITS + 2;

    cmo_pkg::cfg_t                   cfg;
    logic [cmo_pkg::COORD_BITS-1:0]  pointer_col_reg;
    logic [cmo_pkg::COORD_BITS-1:0]  pointer_row_reg;

    logic                            accept;
    logic                            pix_accept;
    logic                            load_we;
    logic                            s1_advance;

    logic signed [CW-1:0]            org_x_raw;
    logic signed [CW-1:0]            org_y_raw;
    logic signed [CW-1:0]            org_x;
    logic signed [CW-1:0]            org_y;
    logic signed [CW-1:0]            dx;
    logic signed [CW-1:0]            dy;
    logic [cmo_pkg::SIZE_BITS-1:0]   w_eff;
    logic [cmo_pkg::SIZE_BITS-1:0]   h_eff;
    logic                            in_win;

    logic                            s1_valid_reg;
    logic [31:0]                     s1_pixel_reg;
    logic [cmo_pkg::COL_BITS-1:0]    s1_col_reg;
    logic                            s1_win_reg;

    logic [cmo_pkg::ROW_W-1:0]       row_clear;
    logic [cmo_pkg::ROW_W-1:0]       row_set;
    logic                            bit_set;
    logic                            bit_clear;

    logic                            out_valid_reg;
    cmo_pkg::result_t                out_reg;
    cmo_pkg::result_t                out_next;

    cmo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_advance = !out_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || s1_advance;
    assign accept     = item_valid && item_ready;
    assign pix_accept = accept && (item.mode == cmo_pkg::MODE_PIXEL);
    assign load_we    = accept && (item.mode == cmo_pkg::MODE_LOAD)
                        && (int'(item.row_index) < cmo_pkg::MASK_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_col_reg <= '0;
            pointer_row_reg <= '0;
        end
        else if (accept && (item.mode == cmo_pkg::MODE_MOVE))
        begin
            pointer_col_reg <= item.new_pointer_x;
            pointer_row_reg <= item.new_pointer_y;
        end
    end

    // Origin is pointer plus hotspot, clamped at zero; then the pixel's offset in the shape.
    always_comb
    begin
        org_x_raw = signed'({2'b00, pointer_col_reg}) + CW'(cfg.hot_x);
        org_y_raw = signed'({2'b00, pointer_row_reg}) + CW'(cfg.hot_y);
        org_x     = org_x_raw[CW-1] ? '0 : org_x_raw;
        org_y     = org_y_raw[CW-1] ? '0 : org_y_raw;
        dx        = signed'({2'b00, item.pixel_x}) - org_x;
        dy        = signed'({2'b00, item.pixel_y}) - org_y;
        w_eff     = (int'(cfg.cursor_width) > cmo_pkg::SIZE_CAP)
                    ? cmo_pkg::SIZE_BITS'(cmo_pkg::SIZE_CAP) : cfg.cursor_width;
        h_eff     = (int'(cfg.cursor_height) > cmo_pkg::SIZE_CAP)
                    ? cmo_pkg::SIZE_BITS'(cmo_pkg::SIZE_CAP) : cfg.cursor_height;
        in_win    = cfg.cursor_enable
                    && !dx[CW-1] && ($unsigned(dx) < CW'(w_eff))
                    && !dy[CW-1] && ($unsigned(dy) < CW'(h_eff));
    end

    // Load and pixel items never share a cycle, so the store's read and write never collide.
    cmo_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (load_we),
        .waddr    (cmo_pkg::ROW_AW'(item.row_index)),
        .wr_clear (item.clear_bits),
        .wr_set   (item.set_bits),
        .re       (pix_accept),
        .raddr    (dy[cmo_pkg::ROW_AW-1:0]),
        .rd_clear (row_clear),
        .rd_set   (row_set)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= pix_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg <= item.pixel_value;
            s1_col_reg   <= dx[cmo_pkg::COL_BITS-1:0];
            s1_win_reg   <= in_win;
        end
    end

    always_comb
    begin
        bit_set   = row_set[cmo_pkg::COL_BITS'(cmo_pkg::ROW_W - 1) - s1_col_reg];
        bit_clear = row_clear[cmo_pkg::COL_BITS'(cmo_pkg::ROW_W - 1) - s1_col_reg];
        out_next.out_pixel  = s1_pixel_reg;
        out_next.cursor_hit = 1'b0;
        priority if (s1_win_reg && bit_set)
        begin
            out_next.out_pixel  = cmo_pkg::PIX_BLACK;
            out_next.cursor_hit = 1'b1;
        end
        else if (s1_win_reg && bit_clear)
        begin
            out_next.out_pixel  = cmo_pkg::PIX_WHITE;
            out_next.cursor_hit = 1'b1;
        end
        else
        begin
            out_next.out_pixel  = s1_pixel_reg;
            out_next.cursor_hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: design/cmo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cmo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/cmo_cfg.sv
// APB register file holding the cursor hotspot, size and enable.
module cmo_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cmo_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output cmo_pkg::cfg_t                  cfg
);

    cmo_pkg::cfg_t                        cfg_reg;
    logic                                 wr_en;
    logic [cmo_pkg::REG_IDX_BITS-1:0]     idx;

    assign pready = 1'b1;
    assign idx    = paddr[cmo_pkg::PADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hot_x         <= -6'sd1;
            cfg_reg.hot_y         <= -6'sd1;
            cfg_reg.cursor_width  <= 6'd16;
            cfg_reg.cursor_height <= 6'd16;
            cfg_reg.cursor_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                cmo_pkg::REG_HOT_X:         cfg_reg.hot_x         <= signed'(pwdata[5:0]);
                cmo_pkg::REG_HOT_Y:         cfg_reg.hot_y         <= signed'(pwdata[5:0]);
                cmo_pkg::REG_CURSOR_WIDTH:  cfg_reg.cursor_width  <= pwdata[5:0];
                cmo_pkg::REG_CURSOR_HEIGHT: cfg_reg.cursor_height <= pwdata[5:0];
                cmo_pkg::REG_CURSOR_ENABLE: cfg_reg.cursor_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            cmo_pkg::REG_HOT_X:         prdata = {26'd0, cfg_reg.hot_x};
            cmo_pkg::REG_HOT_Y:         prdata = {26'd0, cfg_reg.hot_y};
            cmo_pkg::REG_CURSOR_WIDTH:  prdata = {26'd0, cfg_reg.cursor_width};
            cmo_pkg::REG_CURSOR_HEIGHT: prdata = {26'd0, cfg_reg.cursor_height};
            cmo_pkg::REG_CURSOR_ENABLE: prdata = {31'd0, cfg_reg.cursor_enable};
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/cmo_store.sv
// Mask store: both mask rows in one RAM, with per-row valid bits that fall back to the arrow.
module cmo_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [cmo_pkg::ROW_AW-1:0] waddr,
    input  logic [cmo_pkg::ROW_W-1:0]  wr_clear,
    input  logic [cmo_pkg::ROW_W-1:0]  wr_set,
    input  logic                       re,
    input  logic [cmo_pkg::ROW_AW-1:0] raddr,
    output logic [cmo_pkg::ROW_W-1:0]  rd_clear,
    output logic [cmo_pkg::ROW_W-1:0]  rd_set
);

    localparam int DW = 2 * cmo_pkg::ROW_W;

    logic [cmo_pkg::MASK_SIZE-1:0] valid_reg;
    logic                          rd_valid_reg;
    logic [DW-1:0]                 rd_arrow_reg;
    logic [DW-1:0]                 ram_rdata;
    logic [DW-1:0]                 row;

    cmo_ram #(
        .WIDTH (DW),
        .DEPTH (cmo_pkg::MASK_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({wr_clear, wr_set}),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Rows never written since reset still hold the default arrow.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_valid_reg <= valid_reg[raddr];
            rd_arrow_reg <= cmo_pkg::arrow_row(raddr);
        end
    end

    assign row      = rd_valid_reg ? ram_rdata : rd_arrow_reg;
    assign rd_clear = row[DW-1:cmo_pkg::ROW_W];
    assign rd_set   = row[cmo_pkg::ROW_W-1:0];

endmodule

FILE: dv/cursor_overlay_checker.sv
`timescale 1ns / 1ps
// Checker for the cursor overlay: tracks mask, pointer and setup, predicts each composited pixel.
module cursor_overlay_checker
    import cmo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    mismatch_count,
    output int                    pixels_in_flight
);

    cfg_t                  shape_cfg;
    logic [COORD_BITS-1:0] pointer_col;
    logic [COORD_BITS-1:0] pointer_row;
    logic [ROW_W-1:0]      clear_rows [MASK_SIZE];
    logic [ROW_W-1:0]      set_rows [MASK_SIZE];
    result_t               pending_pixels [$];
    result_t               oldest;
    int                    fails = 0;
    int                    in_flight = 0;

    assign mismatch_count   = fails;
    assign pixels_in_flight = in_flight;

    function automatic result_t composite_pixel(input item_t px);
        int      ox;
        int      oy;
        int      dx;
        int      dy;
        int      w;
        int      h;
        result_t r;
        // The origin is clamped at the top-left corner, so the shape shifts rather than clips.
        ox = int'(pointer_col) + int'(shape_cfg.hot_x);
        oy = int'(pointer_row) + int'(shape_cfg.hot_y);
        if (ox < 0)
        begin
            ox = 0;
        end
        if (oy < 0)
        begin
            oy = 0;
        end
        w  = (int'(shape_cfg.cursor_width) > SIZE_CAP) ? SIZE_CAP : int'(shape_cfg.cursor_width);
        h  = (int'(shape_cfg.cursor_height) > SIZE_CAP) ? SIZE_CAP : int'(shape_cfg.cursor_height);
        dx = int'(px.pixel_x) - ox;
        dy = int'(px.pixel_y) - oy;
        r.out_pixel  = px.pixel_value;
        r.cursor_hit = 1'b0;
        if (shape_cfg.cursor_enable && dx >= 0 && dx < w && dy >= 0 && dy < h)
        begin
            // The set mask wins over the clear mask.
            if (set_rows[dy][ROW_W-1-dx])
            begin
                r.out_pixel  = PIX_BLACK;
                r.cursor_hit = 1'b1;
            end
            else if (clear_rows[dy][ROW_W-1-dx])
            begin
                r.out_pixel  = PIX_WHITE;
                r.cursor_hit = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fails < 50)
        begin
            $display("%0t: cursor overlay mismatch on %s: got %h, expected %h",
                     $time, what, got, want);
        end
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_cfg.hot_x         = -6'sd1;
            shape_cfg.hot_y         = -6'sd1;
            shape_cfg.cursor_width  = 6'd16;
            shape_cfg.cursor_height = 6'd16;
            shape_cfg.cursor_enable = 1'b1;
            pointer_col = '0;
            pointer_row = '0;
            for (int r = 0; r < MASK_SIZE; r++)
            begin
                clear_rows[r] = (r < ARROW_ROWS) ? {ARROW_CLR[r], 16'h0000} : '0;
                set_rows[r]   = (r < ARROW_ROWS) ? {ARROW_SET[r], 16'h0000} : '0;
            end
            pending_pixels.delete();
            in_flight = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_BITS-1:2])
                    REG_HOT_X:         shape_cfg.hot_x = pwdata[5:0];
                    REG_HOT_Y:         shape_cfg.hot_y = pwdata[5:0];
                    REG_CURSOR_WIDTH:  shape_cfg.cursor_width = pwdata[SIZE_BITS-1:0];
                    REG_CURSOR_HEIGHT: shape_cfg.cursor_height = pwdata[SIZE_BITS-1:0];
                    REG_CURSOR_ENABLE: shape_cfg.cursor_enable = pwdata[0];
                    default: ;
                endcase
            end

            // Results are matched before new items are taken, since no item can
            // produce a result in the beat that accepts it.
            if (result_valid && result_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    report_mismatch("unexpected result beat", result.out_pixel, '0);
                end
                else
                begin
                    oldest = pending_pixels.pop_front();
                    if (result.out_pixel !== oldest.out_pixel)
                    begin
                        report_mismatch("out_pixel", result.out_pixel, oldest.out_pixel);
                    end
                    if (result.cursor_hit !== oldest.cursor_hit)
                    begin
                        report_mismatch("cursor_hit", 32'(result.cursor_hit),
                                        32'(oldest.cursor_hit));
                    end
                end
            end

            if (item_valid && item_ready)
            begin
                case (item.mode)
                    MODE_PIXEL: pending_pixels.push_back(composite_pixel(item));
                    MODE_LOAD:
                    begin
                        clear_rows[item.row_index] = item.clear_bits;
                        set_rows[item.row_index]   = item.set_bits;
                    end
                    MODE_MOVE:
                    begin
                        pointer_col = item.new_pointer_x;
                        pointer_row = item.new_pointer_y;
                    end
                    default: ;
                endcase
            end
            in_flight = pending_pixels.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the cursor overlay testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;

    import cmo_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 140;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 4;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    fails;
    int                    pixels_in_flight;

    // Shape setups per phase; the seventh phase (index 6) returns to the reset values among others.
    int hot_x_plan  [PHASES] = '{0, -32, 31, 5, -3, 12, -1, 31};
    int hot_y_plan  [PHASES] = '{0, -32, 31, -7, 9, -20, -1, -32};
    int width_plan  [PHASES] = '{32, 63, 33, 0, 20, 32, 16, 7};
    int height_plan [PHASES] = '{32, 63, 1, 12, 0, 32, 16, 29};
    int enable_plan [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};

    // Stimulus-side copy of where the cursor sits, used only to aim pixels at it.
    int                    aim_hx;
    int                    aim_hy;
    logic [COORD_BITS-1:0] aim_ptr_x;
    logic [COORD_BITS-1:0] aim_ptr_y;
    bit                    hold_req = 1'b0;

    cursor_mask_overlay_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    cursor_overlay_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result           (result),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatch_count   (fails),
        .pixels_in_flight (pixels_in_flight)
    );

    always
    begin
        #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t fresh_item(input logic [1:0] mode);
        item_t it;
        it.mode          = mode;
        it.pixel_x       = COORD_BITS'($urandom_range(0, 4095));
        it.pixel_y       = COORD_BITS'($urandom_range(0, 4095));
        it.pixel_value   = $urandom();
        it.row_index     = 5'($urandom_range(0, 31));
        it.clear_bits    = $urandom();
        it.set_bits      = $urandom();
        it.new_pointer_x = COORD_BITS'($urandom_range(0, 4095));
        it.new_pointer_y = COORD_BITS'($urandom_range(0, 4095));
        return it;
    endfunction

    function automatic item_t pixel_item(input int x, input int y, input logic [31:0] v);
        item_t it;
        it             = fresh_item(MODE_PIXEL);
        it.pixel_x     = x[COORD_BITS-1:0];
        it.pixel_y     = y[COORD_BITS-1:0];
        it.pixel_value = v;
        return it;
    endfunction

    function automatic item_t load_item(input int row, input logic [31:0] clr,
                                        input logic [31:0] st);
        item_t it;
        it            = fresh_item(MODE_LOAD);
        it.row_index  = row[4:0];
        it.clear_bits = clr;
        it.set_bits   = st;
        return it;
    endfunction

    function automatic item_t move_item(input int x, input int y);
        item_t it;
        it               = fresh_item(MODE_MOVE);
        it.new_pointer_x = x[COORD_BITS-1:0];
        it.new_pointer_y = y[COORD_BITS-1:0];
        aim_ptr_x        = it.new_pointer_x;
        aim_ptr_y        = it.new_pointer_y;
        return it;
    endfunction

    // Coordinates near the screen edges make the clamp and the far-origin case frequent.
    function automatic int pick_coord();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4095;
            2: return $urandom_range(0, 40);
            3: return $urandom_range(4050, 4095);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int aim_at(input int origin);
        int v;
        if (origin < 0)
        begin
            origin = 0;
        end
        v = origin + $urandom_range(0, 36) - 2;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 4095)
        begin
            v = 4095;
        end
        return v;
    endfunction

    function automatic logic [31:0] mask_bits();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 66)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                return pixel_item(aim_at(int'(aim_ptr_x) + aim_hx),
                                  aim_at(int'(aim_ptr_y) + aim_hy), $urandom());
            end
            return fresh_item(MODE_PIXEL);
        end
        if (r < 78)
        begin
            return load_item($urandom_range(0, 31), mask_bits(), mask_bits());
        end
        if (r < 94)
        begin
            return move_item(pick_coord(), pick_coord());
        end
        return fresh_item(MODE_UNUSED);
    endfunction

    task automatic send_item(input item_t it);
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        wait (pixels_in_flight == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setup(input int p);
        write_reg(REG_HOT_X, hot_x_plan[p] & 32'h3F);
        write_reg(REG_HOT_Y, hot_y_plan[p] & 32'h3F);
        write_reg(REG_CURSOR_WIDTH, width_plan[p]);
        write_reg(REG_CURSOR_HEIGHT, height_plan[p]);
        write_reg(REG_CURSOR_ENABLE, enable_plan[p]);
        aim_hx = hot_x_plan[p];
        aim_hy = hot_y_plan[p];
    endtask

    task automatic run_phase(input bit no_gaps, input bit with_hold, input bit with_pause);
        int    n;
        int    gap;
        bit    held;
        bit    paused;
        item_t it;
        n      = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (n < PHASE_ITEMS)
        begin
            if (with_hold && !held && n == 20)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (with_pause && !paused && n == 70)
            begin
                wait_drained();
                paused = 1'b1;
            end
            it = random_item();
            send_item(it);
            if (it.mode != MODE_UNUSED)
            begin
                n++;
            end
            // While the receiver holds off, keep offering beats so the block backs up.
            gap = (no_gaps || (with_hold && n >= 20 && n < 70)) ? 0 : gap_len();
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Receiver: alternating ready runs and stalls, plus one long hold on request.
    initial
    begin
        int hold_left;
        int left;
        bit rx_on;
        hold_left    = 0;
        left         = 0;
        rx_on        = 1'b0;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (left > 0)
            begin
                left--;
                result_ready <= rx_on;
            end
            else
            begin
                rx_on = !rx_on;
                if (rx_on)
                begin
                    left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                       : $urandom_range(1, 10);
                end
                else
                begin
                    left = gap_len();
                end
                result_ready <= rx_on;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        aim_hx     = -1;
        aim_hy     = -1;
        aim_ptr_x  = '0;
        aim_ptr_y  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default arrow at the top-left corner, back to back, with loads and moves
        // seen by the very next pixel.
        send_item(pixel_item(0, 0, 32'hFFFF_FFFF));
        send_item(pixel_item(1, 1, 32'h1234_5678));
        send_item(pixel_item(15, 15, 32'h00AB_CDEF));
        send_item(pixel_item(16, 3, 32'hFFFF_FFFF));
        send_item(pixel_item(4095, 4095, 32'h0000_0000));
        send_item(fresh_item(MODE_UNUSED));
        send_item(load_item(0, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(pixel_item(0, 0, 32'h0000_0000));
        send_item(load_item(31, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(load_item(2, 32'h0000_0000, 32'h0000_0000));
        send_item(pixel_item(2, 2, 32'h5555_AAAA));
        send_item(load_item(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(pixel_item(3, 3, 32'hAAAA_5555));
        send_item(move_item(4095, 4095));
        send_item(pixel_item(4095, 4095, 32'hFFFF_FFFF));
        send_item(pixel_item(4094, 4094, 32'h0000_0000));
        send_item(pixel_item(4093, 4094, 32'h0F0F_0F0F));
        send_item(move_item(0, 4095));
        send_item(pixel_item(0, 4094, 32'hF0F0_F0F0));
        send_item(move_item(0, 0));
        send_item(pixel_item(0, 0, 32'h8000_0001));
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            apply_setup(p);
            run_phase(p == 1, p == 3, p == 4);
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        repeat (8) @(posedge clk);
        if (fails == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
